// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands shared by the converter RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rycc_pkg.sv =====
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// No dependencies; the other RTL files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rycc_pkg;

   // Register and size limits
   localparam int SIZE_W        = 13;
   localparam int ROW_W         = 12;
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

   // Queue depths (powers of two)
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // Pair-sum layout: Cb in the low half, Cr in the high half
   localparam int HALF_W = 9;
   localparam int PAIR_W = 2 * HALF_W;

   // BT.601 coefficients, 16-bit datapath
   localparam logic [15:0] COEF_Y_R  = 16'd66;
   localparam logic [15:0] COEF_Y_G  = 16'd129;
   localparam logic [15:0] COEF_Y_B  = 16'd25;
   localparam logic [15:0] COEF_CB_R = 16'd38;
   localparam logic [15:0] COEF_CB_G = 16'd74;
   localparam logic [15:0] COEF_CB_B = 16'd112;
   localparam logic [15:0] COEF_CR_R = 16'd112;
   localparam logic [15:0] COEF_CR_G = 16'd94;
   localparam logic [15:0] COEF_CR_B = 16'd18;
   localparam logic [15:0] ROUND_HALF   = 16'd128;
   // 32768 offset turns the floor shift into an unsigned shift, plus rounding
   localparam logic [15:0] CHROMA_BIAS  = 16'd32896;

   localparam logic [7:0] LUMA_OFFSET = 8'd16;
   localparam logic [7:0] LUMA_MAX    = 8'd235;
   localparam logic [7:0] CHROMA_MIN  = 8'd16;
   localparam logic [7:0] CHROMA_MAX  = 8'd240;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb_avg;
      logic [7:0] cr_avg;
      logic       frame_end;
   } result_type;

   // Position tags attached to each word by the front end
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic frame_end;
   } pixel_tag_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rycc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rycc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2048
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rycc_fifo.sv =====
// Small flop-based queue with the head word visible on the read side.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rycc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             wdata,
   output      logic                         full,
   input  wire logic                         pop,
   output      logic [WIDTH-1:0]             rdata,
   output      logic                         empty,
   output      logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign count   = count_ff;

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rycc_front.sv =====
// Front end: frame size registers, raster position counters and word tagging.
// Depends on rycc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rycc_front #(
   parameter int MAX_WIDTH = rycc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_we,
   input  wire rycc_pkg::csr_index_type         csr_index,
   input  wire logic [rycc_pkg::SIZE_W-1:0]     csr_wdata,
   // pixel input
   input  wire logic                            req_push,
   input  wire rycc_pkg::pixel_type             req_data,
   output      logic                            req_full,
   // toward the middle queue
   input  wire logic                            mid_full,
   output      logic                            mid_push,
   output      rycc_pkg::pixel_tag_type         mid_tag,
   output      logic [((MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] mid_idx,
   output      rycc_pkg::pixel_type             mid_pixel
);

   localparam int IW   = ((MAX_WIDTH/2) > 1) ? $clog2(MAX_WIDTH/2) : 1;
   localparam int CW   = IW + 1;
   localparam int WLIM = (MAX_WIDTH / 2) * 2;
   localparam int EW   = ($clog2(WLIM + 1) > rycc_pkg::SIZE_W) ?
                         $clog2(WLIM + 1) : rycc_pkg::SIZE_W;
   localparam int SW   = rycc_pkg::SIZE_W;
   localparam int RW   = rycc_pkg::ROW_W;

   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [EW-1:0] width_even, width_eff;
   logic [SW-1:0] height_even, height_eff;
   logic          last_col, last_row, accept;

   // Effective sizes: even, saturated, at least two
   always_comb begin
      width_even = EW'({width_ff[SW-1:1], 1'b0});
      width_eff  = width_even;
      if (width_even > EW'(WLIM)) begin
         width_eff = EW'(WLIM);
      end
      if (width_eff < EW'(2)) begin
         width_eff = EW'(2);
      end
      height_even = {height_ff[SW-1:1], 1'b0};
      height_eff  = height_even;
      if (height_even > SW'(rycc_pkg::MAX_HEIGHT)) begin
         height_eff = SW'(rycc_pkg::MAX_HEIGHT);
      end
      if (height_eff < SW'(2)) begin
         height_eff = SW'(2);
      end
   end

   assign last_col = (EW'(col_ff) >= (width_eff - 1'b1));
   assign last_row = (SW'(row_ff) >= (height_eff - 1'b1));
   assign accept   = req_push && !mid_full;

   assign req_full  = mid_full;
   assign mid_push  = accept;
   assign mid_pixel = req_data;
   assign mid_idx   = col_ff[CW-1:1];
   assign mid_tag   = '{col_odd:   col_ff[0],
                        row_odd:   row_ff[0],
                        frame_end: last_col && last_row};

   // Configuration writes and raster position update
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            rycc_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            rycc_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rycc_pkg::RESET_WIDTH;
         height_ff <= rycc_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rycc_back.sv =====
// Back end: color conversion, pair sums, line store and 2x2 chroma averaging.
// Depends on rycc_pkg, rycc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rycc_back #(
   parameter int MAX_WIDTH = rycc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // from the middle queue
   input  wire logic                                mid_empty,
   input  wire rycc_pkg::pixel_tag_type             mid_tag,
   input  wire logic [((MAX_WIDTH/2) > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] mid_idx,
   input  wire rycc_pkg::pixel_type                 mid_pixel,
   output      logic                                mid_pop,
   // toward the result queue
   input  wire logic [$clog2(rycc_pkg::OUT_DEPTH+1)-1:0] out_count,
   output      logic                                out_push,
   output      rycc_pkg::result_type                out_data
);

   localparam int IW      = ((MAX_WIDTH/2) > 1) ? $clog2(MAX_WIDTH/2) : 1;
   localparam int ENTRIES = MAX_WIDTH / 2;
   localparam int ODEPTH  = rycc_pkg::OUT_DEPTH;
   localparam int CNW     = $clog2(ODEPTH + 1);
   localparam int HW      = rycc_pkg::HALF_W;
   localparam int PW      = rycc_pkg::PAIR_W;

   // issue and forwarding
   logic [CNW:0]             credit_use;
   logic                     issue;
   logic                     fwd_hit_ff;
   logic [PW-1:0]            fwd_data_ff;
   logic [PW-1:0]            ram_rdata;
   logic [PW-1:0]            line_rd;
   // stage 1
   logic                     s1_v_ff;
   rycc_pkg::pixel_tag_type  s1_tag_ff;
   logic [IW-1:0]            s1_idx_ff;
   rycc_pkg::pixel_type      s1_pix_ff;
   logic [15:0]              luma_sum, cb_sum, cr_sum;
   logic [7:0]               luma_raw, luma_s1;
   // stage 2
   logic                     s2_v_ff;
   rycc_pkg::pixel_tag_type  s2_tag_ff;
   logic [IW-1:0]            s2_idx_ff;
   logic [7:0]               s2_luma_ff, s2_cb_ff, s2_cr_ff;
   logic [PW-1:0]            s2_line_ff;
   logic [PW-1:0]            pair_ff, pair_in;
   logic [HW:0]              pcb, pcr;
   logic [HW+1:0]            scb, scr;
   logic [HW-1:0]            qcb, qcr;
   logic [7:0]               cb_out, cr_out;
   logic                     line_wr;
   logic [PW-1:0]            line_wdata;
   logic                     chroma_valid;

   // Issue only with room reserved in the result queue for words in flight
   assign credit_use = (CNW+1)'(out_count) + (CNW+1)'(s1_v_ff) + (CNW+1)'(s2_v_ff);
   assign issue      = !mid_empty && (credit_use < (CNW+1)'(ODEPTH));
   assign mid_pop    = issue;

   rycc_ram #(
      .WIDTH (PW),
      .DEPTH (ENTRIES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s2_idx_ff),
      .wr_data (line_wdata),
      .rd_en   (issue),
      .rd_addr (mid_idx),
      .rd_data (ram_rdata)
   );

   // Stage 1: color matrix
   always_comb begin
      luma_sum = rycc_pkg::COEF_Y_R * 16'(s1_pix_ff.red)
               + rycc_pkg::COEF_Y_G * 16'(s1_pix_ff.green)
               + rycc_pkg::COEF_Y_B * 16'(s1_pix_ff.blue)
               + rycc_pkg::ROUND_HALF;
      cb_sum   = rycc_pkg::CHROMA_BIAS
               + rycc_pkg::COEF_CB_B * 16'(s1_pix_ff.blue)
               - rycc_pkg::COEF_CB_R * 16'(s1_pix_ff.red)
               - rycc_pkg::COEF_CB_G * 16'(s1_pix_ff.green);
      cr_sum   = rycc_pkg::CHROMA_BIAS
               + rycc_pkg::COEF_CR_R * 16'(s1_pix_ff.red)
               - rycc_pkg::COEF_CR_G * 16'(s1_pix_ff.green)
               - rycc_pkg::COEF_CR_B * 16'(s1_pix_ff.blue);
      luma_raw = luma_sum[15:8] + rycc_pkg::LUMA_OFFSET;
      luma_s1  = (luma_raw > rycc_pkg::LUMA_MAX) ? rycc_pkg::LUMA_MAX : luma_raw;
      line_rd  = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   end

   // Stage 2: pair sums, line store write, 2x2 average
   always_comb begin
      pcb = (HW+1)'(pair_ff[HW-1:0]) + (HW+1)'(s2_cb_ff);
      pcr = (HW+1)'(pair_ff[PW-1:HW]) + (HW+1)'(s2_cr_ff);
      scb = (HW+2)'(pcb) + (HW+2)'(s2_line_ff[HW-1:0]) + (HW+2)'(2);
      scr = (HW+2)'(pcr) + (HW+2)'(s2_line_ff[PW-1:HW]) + (HW+2)'(2);
      qcb = scb[HW+1:2];
      qcr = scr[HW+1:2];
      cb_out = (qcb < HW'(rycc_pkg::CHROMA_MIN)) ? rycc_pkg::CHROMA_MIN :
               (qcb > HW'(rycc_pkg::CHROMA_MAX)) ? rycc_pkg::CHROMA_MAX : qcb[7:0];
      cr_out = (qcr < HW'(rycc_pkg::CHROMA_MIN)) ? rycc_pkg::CHROMA_MIN :
               (qcr > HW'(rycc_pkg::CHROMA_MAX)) ? rycc_pkg::CHROMA_MAX : qcr[7:0];

      line_wdata   = {pcr[HW-1:0], pcb[HW-1:0]};
      line_wr      = s2_v_ff && s2_tag_ff.col_odd && !s2_tag_ff.row_odd;
      chroma_valid = s2_tag_ff.col_odd && s2_tag_ff.row_odd;

      pair_in = pair_ff;
      if (s2_v_ff && !s2_tag_ff.col_odd) begin
         pair_in = {HW'(s2_cr_ff), HW'(s2_cb_ff)};
      end

      out_push = s2_v_ff;
      out_data = '{luma:         s2_luma_ff,
                   chroma_valid: chroma_valid,
                   cb_avg:       chroma_valid ? cb_out : 8'd0,
                   cr_avg:       chroma_valid ? cr_out : 8'd0,
                   frame_end:    s2_tag_ff.frame_end};
   end

   // Advance valid flags and the pair register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         fwd_hit_ff <= 1'b0;
         pair_ff    <= '0;
      end else begin
         s1_v_ff    <= issue;
         s2_v_ff    <= s1_v_ff;
         fwd_hit_ff <= issue && line_wr && (s2_idx_ff == mid_idx);
         pair_ff    <= pair_in;
      end
   end

   // Hold stage payloads; forward a line write that meets a read of the same entry
   always_ff @(posedge clock) begin
      fwd_data_ff <= line_wdata;
      if (issue) begin
         s1_tag_ff <= mid_tag;
         s1_idx_ff <= mid_idx;
         s1_pix_ff <= mid_pixel;
      end
      if (s1_v_ff) begin
         s2_tag_ff  <= s1_tag_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_luma_ff <= luma_s1;
         s2_cb_ff   <= cb_sum[15:8];
         s2_cr_ff   <= cr_sum[15:8];
         s2_line_ff <= line_rd;
      end
   end

   `ASSERT_IMPLY(a_out_room, clock, reset, s2_v_ff, out_count < CNW'(ODEPTH), "result queue overrun")
   `ASSERT_IMPLY(a_fwd_valid, clock, reset, fwd_hit_ff, s1_v_ff, "forward without a read in flight")
   `ASSERT_NEXT(a_no_stall, clock, reset, s1_v_ff, s2_v_ff, "pipeline dropped a word")
   `ASSERT_IMPLY(a_credit, clock, reset, issue, credit_use < (CNW+1)'(ODEPTH), "issue beyond credit")

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_ycbcr_420_converter.sv =====
// RGB to BT.601 YCbCr 4:2:0 converter.
// Usage:
//   Pixels enter in raster order on the request queue: a word is taken at a
//   rising edge with req_push high and req_full low. Every pixel gives one
//   result word on the response queue: it sits on rsp_data while rsp_empty is
//   low and leaves at an edge with rsp_pop high. The result carries the luma
//   of the pixel; on the odd pixel of an odd row it also carries the averaged
//   Cb/Cr of the 2x2 block (chroma_valid set). frame_end marks the last pixel.
//   Frame size is written through csr_we/csr_index/csr_wdata while idle.
// Timing:
//   One pixel per clock sustained while rsp_pop drains the result queue.
//   A result reaches the response side via the middle queue, the color
//   matrix stage (line store read), then the pair-sum and averaging stage.
// Reset:
//   Synchronous, active high; counters restart at row 0, column 0, queues
//   empty, size 640x480. The line store is not cleared; an even row fills it.
// Stall:
//   Holding rsp_pop low fills the four-word result queue, then the middle
//   queue, then raises req_full; nothing is lost.
// Depends on rycc_pkg, rycc_fifo, rycc_front, rycc_back and rycc_ram.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr_420_converter #(
   parameter int MAX_WIDTH = rycc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_we,
   input  wire rycc_pkg::csr_index_type       csr_index,
   input  wire logic [rycc_pkg::SIZE_W-1:0]   csr_wdata,
   // pixel input
   input  wire logic                          req_push,
   input  wire rycc_pkg::pixel_type           req_data,
   output      logic                          req_full,
   // results
   output      logic                          rsp_empty,
   input  wire logic                          rsp_pop,
   output      rycc_pkg::result_type          rsp_data
);

   localparam int IW    = ((MAX_WIDTH/2) > 1) ? $clog2(MAX_WIDTH/2) : 1;
   localparam int PIXW  = $bits(rycc_pkg::pixel_type);
   localparam int TAGW  = $bits(rycc_pkg::pixel_tag_type);
   localparam int MIDW  = PIXW + TAGW + IW;
   localparam int RESW  = $bits(rycc_pkg::result_type);
   localparam int OCNW  = $clog2(rycc_pkg::OUT_DEPTH + 1);
   localparam int MCNW  = $clog2(rycc_pkg::MID_DEPTH + 1);

   logic                     mid_push, mid_full, mid_pop, mid_empty;
   rycc_pkg::pixel_tag_type  fr_tag, bk_tag;
   logic [IW-1:0]            fr_idx, bk_idx;
   rycc_pkg::pixel_type      fr_pixel, bk_pixel;
   logic [MIDW-1:0]          mid_wdata, mid_rdata;
   logic [MCNW-1:0]          mid_count;
   logic                     out_push, out_full;
   rycc_pkg::result_type     out_data;
   logic [RESW-1:0]          rsp_word;
   logic [OCNW-1:0]          out_count;

   rycc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .mid_full  (mid_full),
      .mid_push  (mid_push),
      .mid_tag   (fr_tag),
      .mid_idx   (fr_idx),
      .mid_pixel (fr_pixel)
   );

   // Pack tagged pixel words for the middle queue
   assign mid_wdata = {fr_tag, fr_idx, fr_pixel};
   assign {bk_tag, bk_idx, bk_pixel} = mid_rdata;

   rycc_fifo #(
      .WIDTH (MIDW),
      .DEPTH (rycc_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty),
      .count (mid_count)
   );

   rycc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty || (mid_count == '0)),
      .mid_tag   (bk_tag),
      .mid_idx   (bk_idx),
      .mid_pixel (bk_pixel),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   rycc_fifo #(
      .WIDTH (RESW),
      .DEPTH (rycc_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push && !out_full),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_data = rycc_pkg::result_type'(rsp_word);

endmodule

`default_nettype wire
